// ===== hw/rtl/ahsu_pkg.sv =====
// Package with the types, constants and helper functions of the horizontal smush unit.
`timescale 1ns / 1ps

package ahsu_pkg;

    localparam int unsigned CHAR_W     = 21;
    localparam int unsigned RULES_W    = 6;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned CLASS_W    = 3;

    localparam logic [APB_ADDR_W-1:0] SMUSH_RULES_ADDR = 2'd0;

    localparam logic [CHAR_W-1:0] HARDBLANK = 21'h0000a0;

    localparam logic [6:0] CH_BAR    = 7'h7c;
    localparam logic [6:0] CH_SLASH  = 7'h2f;
    localparam logic [6:0] CH_BSLASH = 7'h5c;
    localparam logic [6:0] CH_LSQ    = 7'h5b;
    localparam logic [6:0] CH_RSQ    = 7'h5d;
    localparam logic [6:0] CH_LCURLY = 7'h7b;
    localparam logic [6:0] CH_RCURLY = 7'h7d;
    localparam logic [6:0] CH_LPAREN = 7'h28;
    localparam logic [6:0] CH_RPAREN = 7'h29;
    localparam logic [6:0] CH_LT     = 7'h3c;
    localparam logic [6:0] CH_GT     = 7'h3e;
    localparam logic [6:0] CH_UNDER  = 7'h5f;
    localparam logic [6:0] CH_UPPER_Y = 7'h59;
    localparam logic [6:0] CH_UPPER_X = 7'h58;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_BAR    = 3'd0,
        CLASS_SLASH  = 3'd1,
        CLASS_SQUARE = 3'd2,
        CLASS_CURLY  = 3'd3,
        CLASS_PAREN  = 3'd4,
        CLASS_ANGLE  = 3'd5,
        CLASS_NONE   = 3'd7
    } bracket_class_t;

    typedef struct packed {
        logic hardblank;
        logic big_x;
        logic opposite;
        logic hierarchy;
        logic underscore;
        logic equal;
    } rule_en_t;

    typedef struct packed {
        logic              merge_ok;
        logic [CHAR_W-1:0] merged_char;
    } smush_result_t;

    function automatic bracket_class_t bracket_class(input logic [6:0] c);
        bracket_class_t cls;
        unique case (c)
            CH_BAR:               cls = CLASS_BAR;
            CH_SLASH, CH_BSLASH:  cls = CLASS_SLASH;
            CH_LSQ, CH_RSQ:       cls = CLASS_SQUARE;
            CH_LCURLY, CH_RCURLY: cls = CLASS_CURLY;
            CH_LPAREN, CH_RPAREN: cls = CLASS_PAREN;
            CH_LT, CH_GT:         cls = CLASS_ANGLE;
            default:              cls = CLASS_NONE;
        endcase
        return cls;
    endfunction

    function automatic logic [CHAR_W-1:0] widen(input logic [6:0] c);
        return {{(CHAR_W-7){1'b0}}, c};
    endfunction

endpackage

// ===== hw/rtl/ascii_art_horizontal_smush_unit.sv =====
// Top level of the horizontal smush unit: input register, rule logic and result register.
//
//  Channel   Direction  Handshake              Payload
//  in        sink       in_valid / in_ready    left_char, right_char
//  out       source     out_valid / out_ready  merge_ok, merged_char
//  cfg       APB slave  psel, penable, pready  paddr, pwdata, prdata
//
// One pair is accepted every cycle unless the output stalls; its result is registered.
// The rule logic sits between the input register and the result register.
// Reset clears the valid flags and the rule mask, so nothing merges until configured.
// A stalled output holds both stages; each stage frees up as soon as the next one moves.
`timescale 1ns / 1ps

module ascii_art_horizontal_smush_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ahsu_pkg::CHAR_W-1:0]       left_char,
    input  logic [ahsu_pkg::CHAR_W-1:0]       right_char,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              merge_ok,
    output logic [ahsu_pkg::CHAR_W-1:0]       merged_char,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ahsu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ahsu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ahsu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import ahsu_pkg::*;

    rule_en_t          rules;
    smush_result_t     comb_result;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CHAR_W-1:0] left_reg;
    logic [CHAR_W-1:0] right_reg;
    logic              s1_load;

    logic              s2_valid_reg;
    logic              s2_valid_next;
    smush_result_t     result_reg;
    logic              s2_ready;

    ahsu_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rules   (rules)
    );

    ahsu_rule_logic u_rules (
        .left_char  (left_reg),
        .right_char (right_reg),
        .rules      (rules),
        .result     (comb_result)
    );

    assign s2_ready = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            left_reg  <= left_char;
            right_reg <= right_char;
        end
        if (s2_ready && s1_valid_reg)
        begin
            result_reg <= comb_result;
        end
    end

    assign out_valid   = s2_valid_reg;
    assign merge_ok    = result_reg.merge_ok;
    assign merged_char = result_reg.merged_char;

`ifndef SYNTH
    a_no_merge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !merge_ok |-> merged_char == '0)
        else $error("Result without a merge carries a nonzero character.");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(left_reg) && $stable(right_reg))
        else $error("Input stage lost or changed a stalled pair.");

    a_stage_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready |=> out_valid)
        else $error("Pair moved out of the input stage without reaching the output.");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_reg))
        else $error("Stalled result changed before it was taken.");
`endif

endmodule

// ===== hw/rtl/ahsu_cfg_regs.sv =====
// APB register block holding the smush rule enable mask.
`timescale 1ns / 1ps

module ahsu_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ahsu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ahsu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ahsu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output ahsu_pkg::rule_en_t                rules
);
    import ahsu_pkg::*;

    logic [RULES_W-1:0] rules_reg;
    logic [RULES_W-1:0] rules_next;
    logic               wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == SMUSH_RULES_ADDR);

    always_comb
    begin
        rules_next = rules_reg;
        if (wr_hit)
        begin
            rules_next = pwdata[RULES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_reg <= '0;
        end
        else
        begin
            rules_reg <= rules_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == SMUSH_RULES_ADDR)
        begin
            prdata = {{(APB_DATA_W-RULES_W){1'b0}}, rules_reg};
        end
    end

    assign rules = rules_reg;

endmodule

// ===== hw/rtl/ahsu_rule_logic.sv =====
// Combinational evaluation of the six smush rules for one character pair.
`timescale 1ns / 1ps

module ahsu_rule_logic (
    input  logic [ahsu_pkg::CHAR_W-1:0] left_char,
    input  logic [ahsu_pkg::CHAR_W-1:0] right_char,
    input  ahsu_pkg::rule_en_t          rules,
    output ahsu_pkg::smush_result_t     result
);
    import ahsu_pkg::*;

    logic           both_ascii;
    logic [6:0]     a7;
    logic [6:0]     b7;
    bracket_class_t ca;
    bracket_class_t cb;
    logic           opp_pair;
    logic           ca_valid;
    logic           cb_valid;

    assign a7 = left_char[6:0];
    assign b7 = right_char[6:0];
    assign both_ascii = (left_char[CHAR_W-1:7] == '0) && (right_char[CHAR_W-1:7] == '0);
    assign ca = bracket_class(a7);
    assign cb = bracket_class(b7);
    assign ca_valid = (ca != CLASS_NONE);
    assign cb_valid = (cb != CLASS_NONE);

    assign opp_pair = ((a7 == CH_LSQ)    && (b7 == CH_RSQ))    ||
                      ((a7 == CH_RSQ)    && (b7 == CH_LSQ))    ||
                      ((a7 == CH_LCURLY) && (b7 == CH_RCURLY)) ||
                      ((a7 == CH_RCURLY) && (b7 == CH_LCURLY)) ||
                      ((a7 == CH_LPAREN) && (b7 == CH_RPAREN)) ||
                      ((a7 == CH_RPAREN) && (b7 == CH_LPAREN));

    always_comb
    begin
        result = '0;
        priority if (rules.equal && (left_char == right_char) && (left_char != HARDBLANK))
        begin
            result = '{merge_ok: 1'b1, merged_char: right_char};
        end
        else if (both_ascii && rules.underscore && (a7 == CH_UNDER) && cb_valid)
        begin
            result = '{merge_ok: 1'b1, merged_char: right_char};
        end
        else if (both_ascii && rules.underscore && (b7 == CH_UNDER) && ca_valid)
        begin
            result = '{merge_ok: 1'b1, merged_char: left_char};
        end
        else if (both_ascii && rules.hierarchy && ca_valid && cb_valid && (ca < cb))
        begin
            result = '{merge_ok: 1'b1, merged_char: right_char};
        end
        else if (both_ascii && rules.hierarchy && ca_valid && cb_valid && (ca > cb))
        begin
            result = '{merge_ok: 1'b1, merged_char: left_char};
        end
        else if (both_ascii && rules.opposite && opp_pair)
        begin
            result = '{merge_ok: 1'b1, merged_char: widen(CH_BAR)};
        end
        else if (both_ascii && rules.big_x && (a7 == CH_SLASH) && (b7 == CH_BSLASH))
        begin
            result = '{merge_ok: 1'b1, merged_char: widen(CH_BAR)};
        end
        else if (both_ascii && rules.big_x && (a7 == CH_BSLASH) && (b7 == CH_SLASH))
        begin
            result = '{merge_ok: 1'b1, merged_char: widen(CH_UPPER_Y)};
        end
        else if (both_ascii && rules.big_x && (a7 == CH_GT) && (b7 == CH_LT))
        begin
            result = '{merge_ok: 1'b1, merged_char: widen(CH_UPPER_X)};
        end
        else if (rules.hardblank && (left_char == HARDBLANK) && (right_char == HARDBLANK))
        begin
            result = '{merge_ok: 1'b1, merged_char: HARDBLANK};
        end
        else
        begin
            result = '0;
        end
    end

endmodule
